// ===== src/pbin_pkg.sv =====
// shared types and constants for the projected profile binner
`default_nettype none
package pbin_pkg;
  localparam int BIN_ENTRIES = 1024;
  localparam int BIN_BITS = $clog2(BIN_ENTRIES);
  localparam int COORD_BITS = 12;
  localparam int COORD_W = 12;
  localparam int BIN_W = 10;
  localparam int SUM_W = 48;
  localparam int CNT_W = 24;
  localparam int MEAN_W = 32;
  localparam int PROD_W = 30;
  localparam int PROJ_W = 31;
  localparam int ACC_W = 48;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

  typedef enum logic [2:0] {
    REG_PROJ_COS  = 3'd0,
    REG_PROJ_SIN  = 3'd1,
    REG_CENTER_X2 = 3'd2,
    REG_CENTER_Y2 = 3'd3,
    REG_BIN_SCALE = 3'd4,
    REG_BIN_TOP   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_SUM, S_MUL2, S_BIN, S_RD, S_WR, S_FETCH, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] proj_cos;
    logic signed [15:0] proj_sin;
    logic [12:0]        center_x2;
    logic [12:0]        center_y2;
    logic [15:0]        bin_scale;
    logic [9:0]         bin_top;
  } cfg_t;

  typedef struct packed {
    logic in_ready;
    logic clr_write;
    logic mul1;
    logic sum;
    logic mul2;
    logic bin;
    logic mem_rd;
    logic acc_write;
    logic fetch;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  in_op;
    logic in_finite;
    op_t  op;
    logic clr_last;
    logic div_last;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic                    clip;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/pbin_if.sv =====
// input and result channel interfaces
`default_nettype none
interface pbin_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [11:0]               pixel_x;
  logic [11:0]               pixel_y;
  logic signed [31:0]        pixel_value;
  logic                      value_finite;
  logic [9:0]                read_bin;
  modport source(output valid, operation, pixel_x, pixel_y, pixel_value, value_finite,
                 read_bin, input ready);
  modport sink(input valid, operation, pixel_x, pixel_y, pixel_value, value_finite,
               read_bin, output ready);
endinterface

interface pbin_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         bin_index;
  logic signed [31:0] bin_mean;
  logic [23:0]        bin_count;
  logic               bin_empty;
  logic               sum_saturated;
  modport source(output valid, bin_index, bin_mean, bin_count, bin_empty, sum_saturated,
                 input ready);
  modport sink(input valid, bin_index, bin_mean, bin_count, bin_empty, sum_saturated,
               output ready);
endinterface
`default_nettype wire

// ===== src/projected_profile_binner_core.sv =====
// accumulate: from acceptance through multiply, sum, multiply, bin select, bin read and bin write, no result
// read: bin read, fetch, then the mean divider steps to the result register
// one transaction at a time, set by the bin read-modify-write and the divider
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous, then a clearing pass zeroes every bin, input not ready
// top level: settings, sequencer and datapath
`default_nettype none
module projected_profile_binner_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pbin_in_if.sink                            in_ch,
  pbin_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pbin_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pbin_pkg::DATA_W-1:0]   pwdata,
  output logic      [pbin_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  pbin_pkg::cfg_t cfg;
  pbin_pkg::cmd_t cmd;
  pbin_pkg::sts_t sts;

  pbin_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pbin_ctrl u_ctrl (.clk(clk), .rst(rst), .sts(sts), .cmd(cmd));

  pbin_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ===== src/pbin_cfg.sv =====
// apb register file for the binner settings
`default_nettype none
module pbin_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pbin_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pbin_pkg::DATA_W-1:0]   pwdata,
  output logic      [pbin_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output pbin_pkg::cfg_t                     cfg
);
  pbin_pkg::reg_idx_t idx;
  logic wr;

  assign idx = pbin_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.proj_cos  <= 16'sd32767;
      cfg.proj_sin  <= '0;
      cfg.center_x2 <= '0;
      cfg.center_y2 <= '0;
      cfg.bin_scale <= 16'd256;
      cfg.bin_top   <= 10'd1023;
    end else if (wr) begin
      case (idx)
        pbin_pkg::REG_PROJ_COS:  cfg.proj_cos  <= pwdata[15:0];
        pbin_pkg::REG_PROJ_SIN:  cfg.proj_sin  <= pwdata[15:0];
        pbin_pkg::REG_CENTER_X2: cfg.center_x2 <= pwdata[12:0];
        pbin_pkg::REG_CENTER_Y2: cfg.center_y2 <= pwdata[12:0];
        pbin_pkg::REG_BIN_SCALE: cfg.bin_scale <= pwdata[15:0];
        pbin_pkg::REG_BIN_TOP:   cfg.bin_top   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pbin_pkg::REG_PROJ_COS:  prdata = 32'(cfg.proj_cos);
      pbin_pkg::REG_PROJ_SIN:  prdata = 32'(cfg.proj_sin);
      pbin_pkg::REG_CENTER_X2: prdata = {19'b0, cfg.center_x2};
      pbin_pkg::REG_CENTER_Y2: prdata = {19'b0, cfg.center_y2};
      pbin_pkg::REG_BIN_SCALE: prdata = {16'b0, cfg.bin_scale};
      pbin_pkg::REG_BIN_TOP:   prdata = {22'b0, cfg.bin_top};
      default:                 prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/pbin_ctrl.sv =====
// sequencer for accumulate, read-and-clear and the post-reset clearing pass
`default_nettype none
module pbin_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  pbin_pkg::sts_t      sts,
  output pbin_pkg::cmd_t      cmd
);
  pbin_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbin_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      pbin_pkg::S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = pbin_pkg::S_IDLE;
      end
      pbin_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          if (sts.in_op == pbin_pkg::OP_READ) state_next = pbin_pkg::S_RD;
          else if (sts.in_finite) state_next = pbin_pkg::S_MUL1;
        end
      end
      pbin_pkg::S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = pbin_pkg::S_SUM;
      end
      pbin_pkg::S_SUM: begin
        cmd.sum = 1'b1;
        state_next = pbin_pkg::S_MUL2;
      end
      pbin_pkg::S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = pbin_pkg::S_BIN;
      end
      pbin_pkg::S_BIN: begin
        cmd.bin = 1'b1;
        state_next = pbin_pkg::S_RD;
      end
      pbin_pkg::S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = (sts.op == pbin_pkg::OP_READ) ? pbin_pkg::S_FETCH : pbin_pkg::S_WR;
      end
      pbin_pkg::S_WR: begin
        cmd.acc_write = 1'b1;
        state_next = pbin_pkg::S_IDLE;
      end
      pbin_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = pbin_pkg::S_DIV;
      end
      pbin_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = pbin_pkg::S_OUT;
      end
      pbin_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = pbin_pkg::S_IDLE;
        end
      end
      default: state_next = pbin_pkg::S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/pbin_dp.sv =====
// projection, bin store, accumulate and mean divider
`default_nettype none
module pbin_dp (
  input  wire logic       clk,
  input  wire logic       rst,
  input  pbin_pkg::cfg_t  cfg,
  input  pbin_pkg::cmd_t  cmd,
  output pbin_pkg::sts_t  sts,
  pbin_in_if.sink         in_ch,
  pbin_out_if.source      out_ch
);
  // captured transaction
  pbin_pkg::op_t                      op;
  logic [pbin_pkg::COORD_W-1:0]       px, py;
  logic signed [31:0]                 pval;
  logic [pbin_pkg::BIN_W-1:0]         rbin;

  logic signed [13:0]                 dx, dy;
  logic signed [pbin_pkg::PROD_W-1:0] prod_x, prod_y;
  logic signed [pbin_pkg::PROJ_W-1:0] proj;
  logic signed [pbin_pkg::ACC_W-1:0]  acc, acc_ofs, ofs;
  logic [23:0]                        bsel;
  logic [pbin_pkg::BIN_BITS-1:0]      bin_idx;

  logic [pbin_pkg::BIN_BITS:0]        clr_cnt;
  pbin_pkg::entry_t                   mem [pbin_pkg::BIN_ENTRIES];
  pbin_pkg::entry_t                   rd_data, wd;
  logic [pbin_pkg::BIN_BITS-1:0]      rd_addr, wa;
  logic                               we, in_range;
  logic signed [pbin_pkg::SUM_W:0]    new_sum;

  // divider
  logic [pbin_pkg::CNT_W-1:0]         den;
  logic [pbin_pkg::CNT_W-1:0]         rem;
  logic [pbin_pkg::SUM_W-1:0]         qd;
  logic [pbin_pkg::DIV_CNT_W-1:0]     div_cnt;
  logic                               neg, clip;
  logic [pbin_pkg::CNT_W:0]           shifted, diff;
  logic                               ge;
  logic [pbin_pkg::MEAN_W-1:0]        mean;
  logic                               out_valid;

  assign in_ch.ready = cmd.in_ready;
  assign out_ch.valid = out_valid;

  assign sts.in_valid  = in_ch.valid;
  assign sts.in_op     = pbin_pkg::op_t'(in_ch.operation);
  assign sts.in_finite = in_ch.value_finite;
  assign sts.op        = op;
  assign sts.clr_last  = clr_cnt == (pbin_pkg::BIN_BITS+1)'(pbin_pkg::BIN_ENTRIES - 1);
  assign sts.div_last  = div_cnt == pbin_pkg::DIV_CNT_W'(pbin_pkg::DIV_STEPS - 1);
  assign sts.out_busy  = out_valid && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_ch.valid) begin
      op   <= pbin_pkg::op_t'(in_ch.operation);
      px   <= in_ch.pixel_x & pbin_pkg::COORD_MASK;
      py   <= in_ch.pixel_y & pbin_pkg::COORD_MASK;
      pval <= in_ch.pixel_value;
      rbin <= in_ch.read_bin;
    end
  end

  // offsets from the centre in half-pixel units
  assign dx = $signed({1'b0, px, 1'b0}) - $signed({1'b0, cfg.center_x2});
  assign dy = $signed({1'b0, py, 1'b0}) - $signed({1'b0, cfg.center_y2});
  assign ofs = $signed({15'b0, cfg.bin_top, 23'b0});
  assign acc_ofs = acc + ofs;

  always_comb begin
    bsel = acc_ofs[pbin_pkg::ACC_W-1] ? 24'd0 : {1'b0, acc_ofs[46:24]};
    if (bsel > 24'(cfg.bin_top)) bsel = 24'(cfg.bin_top);
    if (bsel > 24'(pbin_pkg::BIN_ENTRIES - 1)) bsel = 24'(pbin_pkg::BIN_ENTRIES - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_x <= dx * cfg.proj_cos;
      prod_y <= dy * cfg.proj_sin;
    end
    if (cmd.sum) proj <= pbin_pkg::PROJ_W'(prod_x) + pbin_pkg::PROJ_W'(prod_y);
    if (cmd.mul2) acc <= proj * $signed({1'b0, cfg.bin_scale});
    if (cmd.bin) bin_idx <= pbin_pkg::BIN_BITS'(bsel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign in_range = {22'b0, rbin} < 32'(pbin_pkg::BIN_ENTRIES);
  assign rd_addr = (op == pbin_pkg::OP_READ) ? pbin_pkg::BIN_BITS'(rbin) : bin_idx;
  assign new_sum = $signed({rd_data.sum[pbin_pkg::SUM_W-1], rd_data.sum})
                 + $signed({{17{pval[31]}}, pval});

  always_comb begin
    we = 1'b0;
    wa = rd_addr;
    wd = '0;
    if (cmd.clr_write) begin
      we = 1'b1;
      wa = clr_cnt[pbin_pkg::BIN_BITS-1:0];
    end else if (cmd.acc_write) begin
      // a full bin drops the pixel
      we = !(&rd_data.cnt);
      wd.cnt = rd_data.cnt + 1'b1;
      wd.clip = rd_data.clip;
      if (new_sum[pbin_pkg::SUM_W] != new_sum[pbin_pkg::SUM_W-1]) begin
        wd.clip = 1'b1;
        wd.sum = new_sum[pbin_pkg::SUM_W] ? {1'b1, {(pbin_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(pbin_pkg::SUM_W-1){1'b1}}};
      end else begin
        wd.sum = new_sum[pbin_pkg::SUM_W-1:0];
      end
    end else if (cmd.fetch) begin
      we = in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  // restoring divide of |sum| by count, one quotient bit a cycle
  assign shifted = {rem, qd[pbin_pkg::SUM_W-1]};
  assign diff = shifted - {1'b0, den};
  assign ge = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      den     <= in_range ? rd_data.cnt : '0;
      clip    <= in_range && rd_data.clip;
      neg     <= rd_data.sum[pbin_pkg::SUM_W-1];
      qd      <= rd_data.sum[pbin_pkg::SUM_W-1] ? -rd_data.sum : rd_data.sum;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[pbin_pkg::CNT_W-1:0] : shifted[pbin_pkg::CNT_W-1:0];
      qd      <= {qd[pbin_pkg::SUM_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_comb begin
    if (den == '0) begin
      mean = '0;
    end else if (!neg) begin
      mean = (qd > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : qd[31:0];
    end else begin
      mean = (qd > 48'h8000_0000) ? 32'h8000_0000 : -qd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.bin_index     <= rbin;
      out_ch.bin_mean      <= mean;
      out_ch.bin_count     <= den;
      out_ch.bin_empty     <= den == '0;
      out_ch.sum_saturated <= clip;
    end
  end
endmodule
`default_nettype wire

// ===== src/pbin_checker.sv =====
// port-level checks for the binner and their binding
`default_nettype none
module pbin_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  bin_index,
  input wire logic [31:0] bin_mean,
  input wire logic [23:0] bin_count,
  input wire logic        bin_empty
);
  // clearing pass keeps the input closed after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during clearing pass");

  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_index))
    else $error("stalled result changed");

  // no transaction finishes in the cycle after it is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_empty == (bin_count == 24'd0)) && (!bin_empty || bin_mean == 32'd0))
    else $error("empty flag inconsistent");
endmodule

bind projected_profile_binner_core pbin_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .bin_index(out_ch.bin_index),
  .bin_mean(out_ch.bin_mean), .bin_count(out_ch.bin_count), .bin_empty(out_ch.bin_empty)
);
`default_nettype wire
